>>> hdl/swus_pkg.sv
// Types and constants shared by the single-wire UART to SPI bridge.
// No dependencies; compiled first.
package swus_pkg;

    // Operating phase of the bridge
    typedef enum logic [2:0] {
        PH_WAIT  = 3'd0,
        PH_RECV  = 3'd1,
        PH_GUARD = 3'd2,
        PH_SPI   = 3'd3,
        PH_TX    = 3'd4
    } phase_t;

    // Configuration register indexes
    typedef enum logic {
        REG_PERIOD_TOP   = 1'b0,
        REG_SAMPLE_POINT = 1'b1
    } reg_idx_t;

    // Register reset values
    localparam logic [7:0] PERIOD_TOP_RST   = 8'd104;
    localparam logic [7:0] SAMPLE_POINT_RST = 8'd52;

    // Bit counter limits
    localparam logic [4:0] RX_SAMPLES    = 5'd9;
    localparam logic [4:0] GUARD_SAMPLES = 5'd3;
    localparam logic [4:0] SPI_EDGES     = 5'd16;
    localparam logic [4:0] TX_DATA_LAST  = 5'd8;
    localparam logic [4:0] TX_STOP_LAST  = 5'd10;

    // One result item
    typedef struct packed {
        logic       uart_drive_enable;
        logic       uart_drive_level;
        logic       spi_clock;
        logic       spi_mosi;
        logic [2:0] phase;
        logic [7:0] spi_reply;
        logic       reply_done;
    } result_t;

endpackage

>>> hdl/single_wire_uart_to_spi_bridge_core.sv
// Single-wire UART to SPI master bridge: state update, result register and skid stage.
// Depends on swus_pkg.
//
//  channel | handshake                  | payload
//  --------+----------------------------+--------------------------------------------------
//  input   | in_valid / in_ready        | tick, uart_line_in, spi_miso
//  result  | out_valid / out_ready      | uart_drive_enable, uart_drive_level, spi_clock,
//          |                            | spi_mosi, phase, spi_reply, reply_done
//  config  | psel/penable/pwrite/pready | paddr[2] selects period_top or sample_point
//
// One input item per cycle while in_ready is high: the state update is one pass of logic
// from the state registers into the result register, or into the skid stage on a stall.
// A skid stage behind the result register keeps in_ready a pure register output;
// in_ready drops only while the skid stage holds a result.
// rst_n clears all control state asynchronously and restores the register defaults.
module single_wire_uart_to_spi_bridge_core (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        tick,
    input  logic        uart_line_in,
    input  logic        spi_miso,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic        uart_drive_enable,
    output logic        uart_drive_level,
    output logic        spi_clock,
    output logic        spi_mosi,
    output logic [2:0]  phase,
    output logic [7:0]  spi_reply,
    output logic        reply_done,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers
    logic [7:0] period_top_reg;
    logic [7:0] sample_point_reg;

    // Bridge state
    swus_pkg::phase_t phase_reg, phase_next;
    logic [7:0] tick_count_reg, tick_count_next;
    logic [4:0] bit_count_reg, bit_count_next;
    logic [7:0] shift_byte_reg, shift_byte_next;
    logic [7:0] reply_byte_reg, reply_byte_next;
    logic       clock_level_reg, clock_level_next;
    logic       line_level_reg, line_level_next;
    logic       line_enable_reg, line_enable_next;
    logic       miso_latch_reg, miso_latch_next;

    // Result register and skid stage
    swus_pkg::result_t out_reg, out_next;
    swus_pkg::result_t skid_reg, skid_next;
    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;

    logic              in_fire;
    logic              out_fire;
    logic              cfg_write;
    logic              done;
    logic              sample_ev;
    logic              period_ev;
    logic              timer_run;
    logic [7:0]        sp_eff;
    logic [4:0]        bit_inc;
    swus_pkg::result_t result;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Register read back
    always_comb
    begin
        unique case (swus_pkg::reg_idx_t'(paddr[2]))
            swus_pkg::REG_PERIOD_TOP:   prdata = {24'd0, period_top_reg};
            swus_pkg::REG_SAMPLE_POINT: prdata = {24'd0, sample_point_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // Register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_top_reg   <= swus_pkg::PERIOD_TOP_RST;
            sample_point_reg <= swus_pkg::SAMPLE_POINT_RST;
        end
        else if (cfg_write)
        begin
            unique case (swus_pkg::reg_idx_t'(paddr[2]))
                swus_pkg::REG_PERIOD_TOP:   period_top_reg   <= pwdata[7:0];
                swus_pkg::REG_SAMPLE_POINT: sample_point_reg <= pwdata[7:0];
                default:                    ;
            endcase
        end
    end

    // Advance the bit timer; flag sample and period events
    assign timer_run = (phase_reg != swus_pkg::PH_WAIT) && (phase_reg <= swus_pkg::PH_TX)
                       && tick;
    assign sp_eff    = (sample_point_reg < period_top_reg) ? sample_point_reg : period_top_reg;
    assign bit_inc   = bit_count_reg + 5'd1;

    // Next state of the bridge for one input item
    always_comb
    begin
        tick_count_next  = tick_count_reg;
        bit_count_next   = bit_count_reg;
        shift_byte_next  = shift_byte_reg;
        reply_byte_next  = reply_byte_reg;
        clock_level_next = clock_level_reg;
        line_level_next  = line_level_reg;
        line_enable_next = line_enable_reg;
        miso_latch_next  = miso_latch_reg;
        phase_next       = phase_reg;
        period_ev        = 1'b0;
        sample_ev        = 1'b0;
        done             = 1'b0;

        if (timer_run)
        begin
            if (tick_count_reg >= period_top_reg)
            begin
                tick_count_next = 8'd0;
                period_ev       = 1'b1;
            end
            else
            begin
                tick_count_next = tick_count_reg + 8'd1;
            end
            sample_ev = (tick_count_next == sp_eff);
        end

        unique case (phase_reg)
            swus_pkg::PH_RECV:
            begin
                // shift in LSB first; the start bit falls out
                if (sample_ev)
                begin
                    shift_byte_next = {uart_line_in, shift_byte_reg[7:1]};
                    bit_count_next  = bit_inc;
                    if (bit_inc >= swus_pkg::RX_SAMPLES)
                    begin
                        bit_count_next = 5'd0;
                        phase_next     = swus_pkg::PH_GUARD;
                    end
                end
            end
            swus_pkg::PH_GUARD:
            begin
                if (sample_ev)
                begin
                    bit_count_next = bit_inc;
                    if (bit_inc >= swus_pkg::GUARD_SAMPLES)
                    begin
                        bit_count_next   = 5'd0;
                        tick_count_next  = 8'd0;
                        clock_level_next = 1'b0;
                        phase_next       = swus_pkg::PH_SPI;
                    end
                end
            end
            swus_pkg::PH_SPI:
            begin
                // rising edge latches MISO, falling edge shifts it in
                if (period_ev)
                begin
                    clock_level_next = !clock_level_reg;
                    if (!clock_level_reg)
                        miso_latch_next = spi_miso;
                    else
                        shift_byte_next = {shift_byte_reg[6:0], miso_latch_reg};
                    bit_count_next = bit_inc;
                    if (bit_inc >= swus_pkg::SPI_EDGES)
                    begin
                        reply_byte_next  = shift_byte_next;
                        bit_count_next   = 5'd0;
                        tick_count_next  = 8'd0;
                        clock_level_next = 1'b0;
                        line_enable_next = 1'b1;
                        line_level_next  = 1'b0;
                        phase_next       = swus_pkg::PH_TX;
                    end
                end
            end
            swus_pkg::PH_TX:
            begin
                // data bits, two stop bits, then release the line
                if (period_ev)
                begin
                    bit_count_next = bit_inc;
                    if (bit_inc <= swus_pkg::TX_DATA_LAST)
                    begin
                        line_level_next = shift_byte_reg[0];
                        shift_byte_next = {1'b0, shift_byte_reg[7:1]};
                    end
                    else if (bit_inc <= swus_pkg::TX_STOP_LAST)
                    begin
                        line_level_next = 1'b1;
                    end
                    else
                    begin
                        line_level_next  = 1'b1;
                        line_enable_next = 1'b0;
                        bit_count_next   = 5'd0;
                        tick_count_next  = 8'd0;
                        phase_next       = swus_pkg::PH_WAIT;
                        done             = 1'b1;
                    end
                end
            end
            default:
            begin
                // wait for a low start bit
                phase_next = swus_pkg::PH_WAIT;
                if (!uart_line_in)
                begin
                    tick_count_next = 8'd0;
                    bit_count_next  = 5'd0;
                    phase_next      = swus_pkg::PH_RECV;
                end
            end
        endcase
    end

    // Assemble the result from the updated state
    always_comb
    begin
        result.uart_drive_enable = line_enable_next;
        result.uart_drive_level  = line_level_next;
        result.spi_clock         = clock_level_next;
        result.spi_mosi          = shift_byte_next[7];
        result.phase             = phase_next;
        result.spi_reply         = reply_byte_next;
        result.reply_done        = done;
    end

    // Commit the state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= swus_pkg::PH_WAIT;
            tick_count_reg  <= 8'd0;
            bit_count_reg   <= 5'd0;
            shift_byte_reg  <= 8'd0;
            reply_byte_reg  <= 8'd0;
            clock_level_reg <= 1'b0;
            line_level_reg  <= 1'b1;
            line_enable_reg <= 1'b0;
            miso_latch_reg  <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg       <= phase_next;
            tick_count_reg  <= tick_count_next;
            bit_count_reg   <= bit_count_next;
            shift_byte_reg  <= shift_byte_next;
            reply_byte_reg  <= reply_byte_next;
            clock_level_reg <= clock_level_next;
            line_level_reg  <= line_level_next;
            line_enable_reg <= line_enable_next;
            miso_latch_reg  <= miso_latch_next;
        end
    end

    // Steer results into the output register or the skid stage
    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = result;
                out_valid_next = in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // Drive the result ports
    assign out_valid         = out_valid_reg;
    assign uart_drive_enable = out_reg.uart_drive_enable;
    assign uart_drive_level  = out_reg.uart_drive_level;
    assign spi_clock         = out_reg.spi_clock;
    assign spi_mosi          = out_reg.spi_mosi;
    assign phase             = out_reg.phase;
    assign spi_reply         = out_reg.spi_reply;
    assign reply_done        = out_reg.reply_done;

    // A held skid entry always sits behind a held result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a result while the output register is empty");

    // The line is driven only during transmission
    a_drive_in_tx: assert property (@(posedge clk) disable iff (!rst_n)
        line_enable_reg |-> (phase_reg == swus_pkg::PH_TX))
        else $error("UART line driven outside the transmit phase");

    // SCLK rises only during the SPI exchange
    a_sclk_in_spi: assert property (@(posedge clk) disable iff (!rst_n)
        clock_level_reg |-> (phase_reg == swus_pkg::PH_SPI))
        else $error("SPI clock high outside the exchange");

    // A completion result shows the line released and the bridge waiting
    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.reply_done) |->
            (!out_reg.uart_drive_enable && (out_reg.phase == swus_pkg::PH_WAIT)))
        else $error("reply_done without releasing the line");

    // The bit counter never passes the SPI edge count
    a_bit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg <= swus_pkg::SPI_EDGES)
        else $error("bit counter out of range");

endmodule

>>> tb/tb.sv
// Self-checking testbench for single_wire_uart_to_spi_bridge_core: drives UART frames,
// SPI replies and timer ticks, predicts every output transfer and compares it.
// Depends on swus_pkg and the bridge core RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_SHARE = 40;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        tick;
    logic        uart_line_in;
    logic        spi_miso;
    logic        out_valid;
    logic        out_ready;
    logic        uart_drive_enable;
    logic        uart_drive_level;
    logic        spi_clock;
    logic        spi_mosi;
    logic [2:0]  phase;
    logic [7:0]  spi_reply;
    logic        reply_done;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predicted bridge state and register copy
    swus_pkg::phase_t pr_phase;
    logic [7:0] pr_ticks;
    logic [4:0] pr_bits;
    logic [7:0] pr_shift;
    logic [7:0] pr_reply;
    logic       pr_sclk;
    logic       pr_line;
    logic       pr_drive;
    logic       pr_miso_hold;
    logic [7:0] cfg_top;
    logic [7:0] cfg_sample;

    swus_pkg::result_t expected_outputs[$];

    int  errors;
    int  items_sent;
    int  results_seen;
    int  replies_seen;
    int  settings_used;
    int  holdoffs_done;
    int  cycle_count;
    int  ready_holdoff_cycles;
    bit  tx_idle_on;
    bit  rx_idle_on;
    bit  every_tick;
    bit  valid_on;

    single_wire_uart_to_spi_bridge_core uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .tick              (tick),
        .uart_line_in      (uart_line_in),
        .spi_miso          (spi_miso),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .uart_drive_enable (uart_drive_enable),
        .uart_drive_level  (uart_drive_level),
        .spi_clock         (spi_clock),
        .spi_mosi          (spi_mosi),
        .phase             (phase),
        .spi_reply         (spi_reply),
        .reply_done        (reply_done),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort on a hung run
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES)
            begin
                $display("timeout after %0d cycles, %0d results pending",
                         cycle_count, expected_outputs.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic draw_tick();
        if (every_tick)
            return 1'b1;
        return $urandom_range(0, 3) != 0;
    endfunction

    // Present the reply bit ahead of each rising SCLK edge, noise elsewhere
    function automatic logic miso_for(input logic [7:0] reply);
        if (pr_phase == swus_pkg::PH_SPI && !pr_sclk)
            return reply[3'd7 - pr_bits[3:1]];
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic reset_prediction();
        pr_phase     = swus_pkg::PH_WAIT;
        pr_ticks     = '0;
        pr_bits      = '0;
        pr_shift     = '0;
        pr_reply     = '0;
        pr_sclk      = 1'b0;
        pr_line      = 1'b1;
        pr_drive     = 1'b0;
        pr_miso_hold = 1'b0;
        cfg_top      = swus_pkg::PERIOD_TOP_RST;
        cfg_sample   = swus_pkg::SAMPLE_POINT_RST;
    endtask

    // Advance the predicted bridge by one accepted transfer and queue its outputs
    task automatic advance_bridge(input logic t, input logic l, input logic m);
        logic [7:0]        sp;
        logic              sample_hit;
        logic              period_hit;
        logic              done;
        swus_pkg::result_t r;
        sample_hit = 1'b0;
        period_hit = 1'b0;
        done       = 1'b0;
        if (pr_phase != swus_pkg::PH_WAIT && t)
        begin
            sp = (cfg_sample < cfg_top) ? cfg_sample : cfg_top;
            if (pr_ticks >= cfg_top)
            begin
                pr_ticks   = '0;
                period_hit = 1'b1;
            end
            else
            begin
                pr_ticks = pr_ticks + 8'd1;
            end
            sample_hit = (pr_ticks == sp);
        end
        case (pr_phase)
            swus_pkg::PH_RECV:
            begin
                if (sample_hit)
                begin
                    pr_shift = {l, pr_shift[7:1]};
                    pr_bits  = pr_bits + 5'd1;
                    if (pr_bits >= swus_pkg::RX_SAMPLES)
                    begin
                        pr_bits  = '0;
                        pr_phase = swus_pkg::PH_GUARD;
                    end
                end
            end
            swus_pkg::PH_GUARD:
            begin
                if (sample_hit)
                begin
                    pr_bits = pr_bits + 5'd1;
                    if (pr_bits >= swus_pkg::GUARD_SAMPLES)
                    begin
                        pr_bits  = '0;
                        pr_ticks = '0;
                        pr_sclk  = 1'b0;
                        pr_phase = swus_pkg::PH_SPI;
                    end
                end
            end
            swus_pkg::PH_SPI:
            begin
                if (period_hit)
                begin
                    pr_sclk = ~pr_sclk;
                    if (pr_sclk)
                        pr_miso_hold = m;
                    else
                        pr_shift = {pr_shift[6:0], pr_miso_hold};
                    pr_bits = pr_bits + 5'd1;
                    if (pr_bits >= swus_pkg::SPI_EDGES)
                    begin
                        pr_reply = pr_shift;
                        pr_bits  = '0;
                        pr_ticks = '0;
                        pr_sclk  = 1'b0;
                        pr_drive = 1'b1;
                        pr_line  = 1'b0;
                        pr_phase = swus_pkg::PH_TX;
                    end
                end
            end
            swus_pkg::PH_TX:
            begin
                if (period_hit)
                begin
                    pr_bits = pr_bits + 5'd1;
                    if (pr_bits <= swus_pkg::TX_DATA_LAST)
                    begin
                        pr_line  = pr_shift[0];
                        pr_shift = pr_shift >> 1;
                    end
                    else if (pr_bits <= swus_pkg::TX_STOP_LAST)
                    begin
                        pr_line = 1'b1;
                    end
                    else
                    begin
                        pr_line  = 1'b1;
                        pr_drive = 1'b0;
                        pr_bits  = '0;
                        pr_ticks = '0;
                        pr_phase = swus_pkg::PH_WAIT;
                        done     = 1'b1;
                    end
                end
            end
            default:
            begin
                pr_phase = swus_pkg::PH_WAIT;
                if (!l)
                begin
                    pr_ticks = '0;
                    pr_bits  = '0;
                    pr_phase = swus_pkg::PH_RECV;
                end
            end
        endcase
        r.uart_drive_enable = pr_drive;
        r.uart_drive_level  = pr_line;
        r.spi_clock         = pr_sclk;
        r.spi_mosi          = pr_shift[7];
        r.phase             = pr_phase;
        r.spi_reply         = pr_reply;
        r.reply_done        = done;
        expected_outputs.push_back(r);
    endtask

    // Idle the sender for a random gap after a transfer
    task automatic sender_gap();
        int g;
        g = tx_idle_on ? pick_gap() : 0;
        if (g != 0)
        begin
            in_valid <= 1'b0;
            valid_on = 0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Offer one input transfer, hold it until accepted, then predict it
    task automatic send_item(input logic t, input logic l, input logic m);
        tick         <= t;
        uart_line_in <= l;
        spi_miso     <= m;
        in_valid     <= 1'b1;
        valid_on = 1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        advance_bridge(t, l, m);
        items_sent++;
        sender_gap();
    endtask

    // Hold off the sender until every predicted output has been checked
    task automatic pause_until_drained();
        if (valid_on)
        begin
            in_valid <= 1'b0;
            valid_on = 0;
        end
        while (expected_outputs.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input swus_pkg::reg_idx_t idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == swus_pkg::REG_PERIOD_TOP)
            cfg_top = val;
        else
            cfg_sample = val;
        @(posedge clk);
    endtask

    // Read a register back; sample prdata during the access cycle
    task automatic check_reg(input swus_pkg::reg_idx_t idx, input logic [7:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[7:0] !== want)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("register %s read %h, expected %h", idx.name(), prdata[7:0], want);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] top, input logic [7:0] sp);
        pause_until_drained();
        write_reg(swus_pkg::REG_PERIOD_TOP, top);
        write_reg(swus_pkg::REG_SAMPLE_POINT, sp);
        check_reg(swus_pkg::REG_PERIOD_TOP, top);
        check_reg(swus_pkg::REG_SAMPLE_POINT, sp);
        settings_used++;
    endtask

    // Keep the line high until the bridge is back to waiting for a start bit
    task automatic settle_line(input logic [7:0] reply);
        while (pr_phase != swus_pkg::PH_WAIT)
            send_item(draw_tick(), 1'b1, miso_for(reply));
    endtask

    // Start a frame and keep it in the receive phase for n ticks at the current timing
    task automatic slow_receive(input int n);
        int k;
        send_item(1'b0, 1'b0, 1'b0);
        for (k = 0; k < n; k++)
            send_item(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // One request frame on the line, then serve the SPI reply until the answer is sent
    task automatic run_frame(input logic [7:0] data, input logic [7:0] reply, input bit broken);
        logic [9:0] levels;
        int         b;
        int         ticks;
        int         n_idle;
        logic       t;
        logic       l;
        settle_line(reply);
        n_idle = $urandom_range(0, 4);
        repeat (n_idle) send_item(draw_tick(), 1'b1, 1'($urandom_range(0, 1)));
        // start edge: the timer only runs once the start is seen
        send_item(1'b0, 1'b0, 1'($urandom_range(0, 1)));
        levels = {1'b1, data, 1'b0};
        for (b = 0; b < 10; b++)
        begin
            ticks = 0;
            while (ticks <= int'(cfg_top))
            begin
                t = draw_tick();
                l = broken ? logic'($urandom_range(0, 1)) : levels[b];
                send_item(t, l, miso_for(reply));
                if (t)
                    ticks++;
            end
        end
        settle_line(reply);
    endtask

    task automatic line_noise(input int n);
        repeat (n) send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
    endtask

    task automatic test_register_defaults();
        check_reg(swus_pkg::REG_PERIOD_TOP, swus_pkg::PERIOD_TOP_RST);
        check_reg(swus_pkg::REG_SAMPLE_POINT, swus_pkg::SAMPLE_POINT_RST);
    endtask

    // Reset bit timing: one sample and one wrap, then finish the frame on a short period
    task automatic test_reset_timing();
        tx_idle_on = 0;
        rx_idle_on = 0;
        every_tick = 1;
        slow_receive(110);
        configure(8'd1, 8'd0);
        settle_line(8'hC3);
        pause_until_drained();
    endtask

    task automatic test_pin_extremes();
        tx_idle_on = 1;
        rx_idle_on = 1;
        every_tick = 0;
        configure(8'd1, 8'd0);
        // ignored while waiting with the line high
        send_item(1'b0, 1'b1, 1'b0);
        send_item(1'b1, 1'b1, 1'b1);
        send_item(1'b0, 1'b1, 1'b1);
        send_item(1'b1, 1'b1, 1'b0);
        // start with tick set: the timer must not count on that transfer
        send_item(1'b1, 1'b0, 1'b1);
        send_item(1'b1, 1'b0, 1'b0);
        send_item(1'b0, 1'b1, 1'b1);
        send_item(1'b1, 1'b1, 1'b1);
        settle_line(8'hFF);
        run_frame(8'hFF, 8'h00, 0);
    endtask

    // Zero top: every tick is both a period and a sample
    task automatic test_top_zero();
        configure(8'd0, 8'd0);
        every_tick = 0;
        run_frame(8'h00, 8'hFF, 0);
        run_frame(8'hA5, 8'h3C, 0);
    endtask

    // Sample point beyond the top clamps to the top
    task automatic test_sample_above_top();
        configure(8'd1, 8'd255);
        run_frame(8'h81, 8'h7E, 0);
    endtask

    // Widest timer: count through 255 and wrap, then finish the frame on a zero top
    task automatic test_max_timer();
        configure(8'd255, 8'd255);
        tx_idle_on = 0;
        rx_idle_on = 0;
        every_tick = 1;
        slow_receive(260);
        configure(8'd0, 8'd0);
        settle_line(8'h39);
        pause_until_drained();
    endtask

    // Stall the result side long enough to back up the input side
    task automatic test_backpressure();
        configure(8'd1, 8'd1);
        tx_idle_on = 0;
        rx_idle_on = 0;
        every_tick = 1;
        ready_holdoff_cycles = 300;
        run_frame(8'h96, 8'h69, 0);
        pause_until_drained();
    endtask

    task automatic test_random_traffic();
        int base;
        int s;
        int pick;
        base = items_sent;
        for (s = 0; s < 4; s++)
        begin
            case (s)
                0: configure(8'd1, 8'd0);
                1: configure(8'd0, 8'd0);
                2: configure(8'd2, 8'd1);
                default: configure(8'd1, 8'd200);
            endcase
            while (items_sent - base < (s + 1) * RANDOM_SHARE)
            begin
                tx_idle_on = $urandom_range(0, 3) != 0;
                rx_idle_on = $urandom_range(0, 3) != 0;
                every_tick = $urandom_range(0, 2) == 0;
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    line_noise($urandom_range(5, 30));
                else
                    run_frame(8'($urandom), 8'($urandom), pick == 1);
            end
        end
    endtask

    // Check one output transfer against the oldest prediction
    task automatic compare_result();
        swus_pkg::result_t got;
        swus_pkg::result_t want;
        got = {uart_drive_enable, uart_drive_level, spi_clock, spi_mosi,
               phase, spi_reply, reply_done};
        results_seen++;
        if (got.reply_done)
            replies_seen++;
        if (expected_outputs.size() == 0)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("output transfer %0d arrived with nothing predicted", results_seen);
        end
        else
        begin
            want = expected_outputs.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"output %0d: expected en=%b lvl=%b sclk=%b mosi=%b ph=%0d ",
                              "reply=%h done=%b, got en=%b lvl=%b sclk=%b mosi=%b ph=%0d ",
                              "reply=%h done=%b"}, results_seen,
                             want.uart_drive_enable, want.uart_drive_level, want.spi_clock,
                             want.spi_mosi, want.phase, want.spi_reply, want.reply_done,
                             got.uart_drive_enable, got.uart_drive_level, got.spi_clock,
                             got.spi_mosi, got.phase, got.spi_reply, got.reply_done);
            end
        end
    endtask

    // Result side: check each transfer and drive out_ready with stalls
    initial
    begin
        int stall_left;
        int g;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                compare_result();
            if (ready_holdoff_cycles != 0)
            begin
                stall_left = ready_holdoff_cycles;
                ready_holdoff_cycles = 0;
                holdoffs_done++;
            end
            if (stall_left != 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!rx_idle_on)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                g = pick_gap();
                if (g == 0)
                begin
                    out_ready <= 1'b1;
                end
                else
                begin
                    stall_left = g - 1;
                    out_ready <= 1'b0;
                end
            end
        end
    end

    // Reset, run each test in turn, then report
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        tick         = 1'b0;
        uart_line_in = 1'b1;
        spi_miso     = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        errors       = 0;
        items_sent   = 0;
        results_seen = 0;
        replies_seen = 0;
        settings_used = 0;
        holdoffs_done = 0;
        ready_holdoff_cycles = 0;
        tx_idle_on   = 1;
        rx_idle_on   = 1;
        every_tick   = 0;
        valid_on     = 0;
        reset_prediction();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_defaults();
        test_reset_timing();
        test_pin_extremes();
        test_top_zero();
        test_sample_above_top();
        test_max_timer();
        test_backpressure();
        test_random_traffic();

        pause_until_drained();
        repeat (10) @(posedge clk);
        $display("Sent %0d input transfers and checked %0d output transfers (%0d replies).",
                 items_sent, results_seen, replies_seen);
        $display("Used %0d timer settings and %0d long result stalls; %0d errors.",
                 settings_used, holdoffs_done, errors);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
hdl/swus_pkg.sv
hdl/single_wire_uart_to_spi_bridge_core.sv
tb/tb.sv
